FILE: rtl/assert_macros.svh
// Assertion macros for the huffman code table builder RTL.
// No dependencies; included by huffman_code_table_builder_core, which carries the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent holds in a cycle, so the consequent holds in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent holds in a cycle, so the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/hctb_pkg.sv
// Package for the huffman code table builder: word types, action codes,
// table sizes and the structs passed between the submodules. No dependencies.
package hctb_pkg;

   localparam int NUM_LENGTHS     = 16;
   localparam int MAX_CODE_LENGTH = 16;
   localparam int LEN_W           = 5;
   localparam int LEN_IDX_W       = $clog2(NUM_LENGTHS);
   localparam int CODE_W          = 16;
   localparam int NEXT_W          = CODE_W + 1;
   localparam int DATA_W          = 8;
   localparam int ACT_W           = 2;

   localparam logic [ACT_W-1:0] ACT_START  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_COUNT  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_SYMBOL = 2'd2;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [DATA_W-1:0] data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] symbol;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
      logic              placed;
   } rsp_type;

   // Table write control from the top level.
   typedef struct packed {
      logic              clear;
      logic              load;
      logic [DATA_W-1:0] count;
   } tbl_ctl_type;

   // Result of the next-length search.
   typedef struct packed {
      logic              found;
      logic [LEN_W-1:0]  length;
      logic [DATA_W-1:0] count;
   } tbl_hit_type;

endpackage

FILE: rtl/huffman_code_table_builder_core.sv
// Top level of the huffman code table builder: input word register, table and
// code assignment units, result register. Depends on hctb_pkg, hctb_len_table,
// hctb_code_gen and assert_macros.svh.
//
// The block builds JPEG style canonical Huffman codes from a table header fed
// one word per cycle. A start word clears the table, the next sixteen count
// words give the number of codes at lengths 1 to 16 (later count words are
// dropped), and every symbol word returns one result word holding the symbol,
// its right aligned code and its length, or placed low with zero code and
// length when the code space is exhausted or no loaded length has codes left.
// Codes longer than MAX_CODE_LENGTH are never placed. Start and count words
// return nothing. The block takes one word per cycle. The accepting edge
// registers a symbol word in the input word register; combinational logic
// (priority search for the next nonzero length over the sixteen counts, shift
// of the running code, fit check) then feeds the result register, which loads
// the result once it is free and raises rsp_valid. Throughput drops below one
// word per cycle only while a result waits in the result register with
// rsp_ready low and a symbol word sits behind it; start and count words
// keep flowing past a held result.
`include "assert_macros.svh"

module huffman_code_table_builder_core #(
   parameter int MAX_CODE_LENGTH = hctb_pkg::MAX_CODE_LENGTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hctb_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hctb_pkg::rsp_type rsp_word
);
   import hctb_pkg::*;

   // Input stage register.
   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff;

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_word_ff;

   logic        req_fire;
   logic        out_free;
   logic        is_symbol;
   logic        advance;
   logic        gen_fire;
   logic        gen_clear;
   tbl_ctl_type tbl_ctl;
   tbl_hit_type tbl_hit;
   logic [LEN_W-1:0] cur_length;
   rsp_type     gen_result;

   // Only symbol words need the result register; the others retire at once.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_symbol = (in_word_ff.action == ACT_SYMBOL);
   assign advance   = in_valid_ff && (!is_symbol || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign gen_fire  = advance && is_symbol;
   assign gen_clear = advance && (in_word_ff.action == ACT_START);

   always_comb begin
      tbl_ctl.clear = gen_clear;
      tbl_ctl.load  = advance && (in_word_ff.action == ACT_COUNT);
      tbl_ctl.count = in_word_ff.data;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (gen_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_word;
      end
      if (gen_fire) begin
         rsp_word_ff <= gen_result;
      end
   end

   hctb_len_table u_len_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tbl_ctl),
      .cur_length (cur_length),
      .hit        (tbl_hit)
   );

   hctb_code_gen #(
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
   ) u_code_gen (
      .clock      (clock),
      .reset      (reset),
      .fire       (gen_fire),
      .clear      (gen_clear),
      .symbol     (in_word_ff.data),
      .hit        (tbl_hit),
      .cur_length (cur_length),
      .result     (gen_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // An unplaced symbol carries neither code nor length.
   `ASSERT_IMPL(a_unplaced_empty, clock, reset,
      rsp_valid_ff && !rsp_word_ff.placed,
      (rsp_word_ff.code_bits == '0) && (rsp_word_ff.code_length == '0),
      "unplaced result has code or length")
   // A placed code has a legal length and fits in it.
   `ASSERT_IMPL(a_placed_fits, clock, reset,
      rsp_valid_ff && rsp_word_ff.placed,
      (rsp_word_ff.code_length != '0) &&
      (rsp_word_ff.code_length <= LEN_W'(MAX_CODE_LENGTH)) &&
      ((rsp_word_ff.code_bits >> rsp_word_ff.code_length) == '0),
      "placed code does not fit its length")
   // A start word returns the code generator to the first length.
   `ASSERT_NEXT(a_start_clears, clock, reset, gen_clear, cur_length == '0,
      "start word left a current length")
   // Without a start word the current length never shrinks.
   `ASSERT_NEXT(a_length_monotonic, clock, reset, !gen_clear,
      cur_length >= $past(cur_length), "current length went down")

endmodule

FILE: rtl/hctb_len_table.sv
// Per-length code count table with the next-nonzero-length priority search.
// Depends on hctb_pkg.
module hctb_len_table (
   input  logic                       clock,
   input  logic                       reset,
   input  hctb_pkg::tbl_ctl_type      ctl,
   input  logic [hctb_pkg::LEN_W-1:0] cur_length,
   output hctb_pkg::tbl_hit_type      hit
);
   import hctb_pkg::*;

   logic [DATA_W-1:0]    counts_ff [NUM_LENGTHS];
   logic [LEN_W-1:0]     loaded_ff;
   logic [LEN_W-1:0]     loaded_in;
   logic                 room;
   logic [NUM_LENGTHS-1:0] avail;
   logic [LEN_IDX_W-1:0] pick;

   assign room = (loaded_ff < LEN_W'(NUM_LENGTHS));

   always_comb begin
      loaded_in = loaded_ff;
      if (ctl.clear) begin
         loaded_in = '0;
      end else if (ctl.load && room) begin
         loaded_in = loaded_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else begin
         loaded_ff <= loaded_in;
      end
   end

   // Count storage needs no reset: entries at or above the fill count are never used.
   always_ff @(posedge clock) begin
      if (!ctl.clear && ctl.load && room) begin
         counts_ff[loaded_ff[LEN_IDX_W-1:0]] <= ctl.count;
      end
   end

   // Entry i holds length i+1; it qualifies when loaded, nonzero and above cur_length.
   always_comb begin
      for (int i = 0; i < NUM_LENGTHS; i++) begin
         avail[i] = (counts_ff[i] != '0) && (LEN_W'(i) < loaded_ff) &&
                    (LEN_W'(i) >= cur_length);
      end
   end

   always_comb begin
      pick = '0;
      for (int i = NUM_LENGTHS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            pick = LEN_IDX_W'(i);
         end
      end
   end

   always_comb begin
      hit.found  = |avail;
      hit.length = LEN_W'(pick) + LEN_W'(1);
      hit.count  = counts_ff[pick];
   end

endmodule

FILE: rtl/hctb_code_gen.sv
// Canonical code assignment: running code, current length and codes left.
// Depends on hctb_pkg; takes the length search result from hctb_len_table.
module hctb_code_gen #(
   parameter int MAX_CODE_LENGTH = hctb_pkg::MAX_CODE_LENGTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic                        clear,
   input  logic [hctb_pkg::DATA_W-1:0] symbol,
   input  hctb_pkg::tbl_hit_type       hit,
   output logic [hctb_pkg::LEN_W-1:0]  cur_length,
   output hctb_pkg::rsp_type           result
);
   import hctb_pkg::*;

   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic [DATA_W-1:0] left_ff, left_in;
   logic [NEXT_W-1:0] code_ff, code_in;
   logic              full_ff, full_in;

   logic              step_up;
   logic [LEN_W-1:0]  grow;
   logic [LEN_W-1:0]  len_e;
   logic [DATA_W-1:0] left_e;
   logic [NEXT_W-1:0] code_e;
   logic              has_left;
   logic              over;
   logic              ok;

   assign cur_length = cur_len_ff;

   always_comb begin
      step_up  = (left_ff == '0) && hit.found;
      grow     = hit.length - cur_len_ff;
      len_e    = step_up ? hit.length : cur_len_ff;
      left_e   = step_up ? hit.count : left_ff;
      code_e   = (step_up && !full_ff) ? NEXT_W'(code_ff << grow) : code_ff;
      has_left = (left_e != '0);
      over     = (len_e > LEN_W'(MAX_CODE_LENGTH)) || ((code_e >> len_e) != '0);
      ok       = has_left && !full_ff && !over;
   end

   always_comb begin
      cur_len_in = len_e;
      left_in    = has_left ? left_e - DATA_W'(1) : left_e;
      full_in    = full_ff || (has_left && over);
      code_in    = ok ? code_e + NEXT_W'(1) : code_e;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         cur_len_ff <= '0;
         left_ff    <= '0;
         code_ff    <= '0;
         full_ff    <= 1'b0;
      end else if (fire) begin
         cur_len_ff <= cur_len_in;
         left_ff    <= left_in;
         code_ff    <= code_in;
         full_ff    <= full_in;
      end
   end

   always_comb begin
      result.symbol      = symbol;
      result.code_bits   = ok ? code_e[CODE_W-1:0] : '0;
      result.code_length = ok ? len_e : '0;
      result.placed      = ok;
   end

endmodule
